/* hdl/cubic_spline_interpolator_2d_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the spline interpolator
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SPLINE_INTERPOLATOR_2D_UNIT_ASSERT_SVH
`define CUBIC_SPLINE_INTERPOLATOR_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define CSI2D_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define CSI2D_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hdl/csi2d_pkg.sv */
// ----------------------------------------------------------------------------
// Spline interpolator package
// Command codes, pipeline depth and the stage control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package csi2d_pkg;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_LINEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CUBIC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CATMULL = 2'd2;

  // extra accumulator bits above the coordinate width
  localparam int ACC_GUARD = 5;

  // coefficient stage plus three multiply / round-add pairs
  localparam int LANE_STAGES = 7;
  localparam int NUM_STAGES  = LANE_STAGES + 1;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
    logic                   out_load;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

/* hdl/csi2d_lane.sv */
// ----------------------------------------------------------------------------
// Spline interpolator axis lane
// Builds the curve coefficients of one axis and runs them through a
// three-step pipelined Horner evaluation in the ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module csi2d_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int RATIO_BITS  = 16,
  localparam int AccW = COORD_WIDTH + csi2d_pkg::ACC_GUARD
) (
  input  wire logic                            clk_i,
  input  wire csi2d_pkg::pipe_ctrl_t           ctrl_i,
  input  wire logic [csi2d_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [RATIO_BITS:0]             ratio_i,
  input  wire logic signed [COORD_WIDTH-1:0]   p0_i,
  input  wire logic signed [COORD_WIDTH-1:0]   p1_i,
  input  wire logic signed [COORD_WIDTH-1:0]   p2_i,
  input  wire logic signed [COORD_WIDTH-1:0]   p3_i,
  output logic signed [AccW-1:0]               v_o,
  output logic                                 halve_o
);

  localparam int G  = csi2d_pkg::ACC_GUARD;
  localparam int TW = RATIO_BITS + 2;
  localparam int PW = AccW + TW;

  localparam logic [RATIO_BITS:0]     RONE    = {1'b1, {RATIO_BITS{1'b0}}};
  localparam logic signed [PW-1:0]    HALF    = PW'(1) <<< (RATIO_BITS - 1);
  localparam logic signed [PW-1:0]    HALF_M1 = HALF - PW'(1);

  function automatic logic signed [AccW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + (p[PW-1] ? HALF_M1 : HALF);
    s = s >>> RATIO_BITS;
    return s[AccW-1:0];
  endfunction

  logic signed [AccW-1:0] pe0, pe1, pe2, pe3, a0;
  logic signed [AccW-1:0] c0_d, c1_d, c2_d, c3_d;
  logic                   hv_d;
  logic [RATIO_BITS:0]    t_d;

  assign pe0 = {{G{p0_i[COORD_WIDTH-1]}}, p0_i};
  assign pe1 = {{G{p1_i[COORD_WIDTH-1]}}, p1_i};
  assign pe2 = {{G{p2_i[COORD_WIDTH-1]}}, p2_i};
  assign pe3 = {{G{p3_i[COORD_WIDTH-1]}}, p3_i};
  assign a0  = pe3 - pe2 - pe0 + pe1;
  assign t_d = (ratio_i > RONE) ? RONE : ratio_i;

  always_comb begin
    c0_d = '0;
    c1_d = '0;
    c2_d = pe2 - pe0;
    c3_d = pe1;
    hv_d = 1'b0;
    unique case (cmd_i)
      csi2d_pkg::CMD_LINEAR: begin
        c2_d = pe2 - pe1;
      end
      csi2d_pkg::CMD_CUBIC: begin
        c0_d = a0;
        c1_d = pe0 - pe1 - a0;
      end
      default: begin
        c0_d = pe3 - pe0 + ((pe1 <<< 1) + pe1) - ((pe2 <<< 1) + pe2);
        c1_d = (pe0 <<< 1) - ((pe1 <<< 2) + pe1) + (pe2 <<< 2) - pe3;
        c3_d = pe1 <<< 1;
        hv_d = 1'b1;
      end
    endcase
  end

  logic signed [AccW-1:0] s0_k0_q, s0_k1_q, s0_k2_q, s0_k3_q;
  logic [RATIO_BITS:0]    s0_t_q;
  logic                   s0_hv_q;
  logic signed [PW-1:0]   s1_prod_q;
  logic signed [AccW-1:0] s1_k1_q, s1_k2_q, s1_k3_q;
  logic [RATIO_BITS:0]    s1_t_q;
  logic                   s1_hv_q;
  logic signed [AccW-1:0] s2_v_q, s2_k2_q, s2_k3_q;
  logic [RATIO_BITS:0]    s2_t_q;
  logic                   s2_hv_q;
  logic signed [PW-1:0]   s3_prod_q;
  logic signed [AccW-1:0] s3_k2_q, s3_k3_q;
  logic [RATIO_BITS:0]    s3_t_q;
  logic                   s3_hv_q;
  logic signed [AccW-1:0] s4_v_q, s4_k3_q;
  logic [RATIO_BITS:0]    s4_t_q;
  logic                   s4_hv_q;
  logic signed [PW-1:0]   s5_prod_q;
  logic signed [AccW-1:0] s5_k3_q;
  logic                   s5_hv_q;
  logic signed [AccW-1:0] s6_v_q;
  logic                   s6_hv_q;

  logic signed [TW-1:0]   s0_ts, s2_ts, s4_ts;

  assign s0_ts = $signed({1'b0, s0_t_q});
  assign s2_ts = $signed({1'b0, s2_t_q});
  assign s4_ts = $signed({1'b0, s4_t_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      s0_k0_q <= c0_d;
      s0_k1_q <= c1_d;
      s0_k2_q <= c2_d;
      s0_k3_q <= c3_d;
      s0_t_q  <= t_d;
      s0_hv_q <= hv_d;
    end
    if (ctrl_i.load[1]) begin
      s1_prod_q <= s0_k0_q * s0_ts;
      s1_k1_q   <= s0_k1_q;
      s1_k2_q   <= s0_k2_q;
      s1_k3_q   <= s0_k3_q;
      s1_t_q    <= s0_t_q;
      s1_hv_q   <= s0_hv_q;
    end
    if (ctrl_i.load[2]) begin
      s2_v_q  <= rnd(s1_prod_q) + s1_k1_q;
      s2_k2_q <= s1_k2_q;
      s2_k3_q <= s1_k3_q;
      s2_t_q  <= s1_t_q;
      s2_hv_q <= s1_hv_q;
    end
    if (ctrl_i.load[3]) begin
      s3_prod_q <= s2_v_q * s2_ts;
      s3_k2_q   <= s2_k2_q;
      s3_k3_q   <= s2_k3_q;
      s3_t_q    <= s2_t_q;
      s3_hv_q   <= s2_hv_q;
    end
    if (ctrl_i.load[4]) begin
      s4_v_q  <= rnd(s3_prod_q) + s3_k2_q;
      s4_k3_q <= s3_k3_q;
      s4_t_q  <= s3_t_q;
      s4_hv_q <= s3_hv_q;
    end
    if (ctrl_i.load[5]) begin
      s5_prod_q <= s4_v_q * s4_ts;
      s5_k3_q   <= s4_k3_q;
      s5_hv_q   <= s4_hv_q;
    end
    if (ctrl_i.load[6]) begin
      s6_v_q  <= rnd(s5_prod_q) + s5_k3_q;
      s6_hv_q <= s5_hv_q;
    end
  end

  assign v_o     = s6_v_q;
  assign halve_o = s6_hv_q;

endmodule

`default_nettype wire

/* hdl/csi2d_merge.sv */
// ----------------------------------------------------------------------------
// Spline interpolator merge stage
// Halves the doubled spline sums, saturates both axes to the coordinate
// range and registers the result beat with the combined clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

module csi2d_merge #(
  parameter int COORD_WIDTH = 32,
  localparam int AccW = COORD_WIDTH + csi2d_pkg::ACC_GUARD
) (
  input  wire logic                          clk_i,
  input  wire csi2d_pkg::pipe_ctrl_t         ctrl_i,
  input  wire logic signed [AccW-1:0]        vx_i,
  input  wire logic signed [AccW-1:0]        vy_i,
  input  wire logic                          hx_i,
  input  wire logic                          hy_i,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic                               clip_o
);

  localparam logic signed [AccW-1:0] CMAX =
    {{(AccW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [AccW-1:0] CMIN = ~CMAX;

  function automatic logic [COORD_WIDTH:0] sat(input logic signed [AccW-1:0] v,
                                               input logic hv);
    logic signed [AccW-1:0] h;
    h = hv ? ((v + $signed({{(AccW-1){1'b0}}, ~v[AccW-1]})) >>> 1) : v;
    if (h > CMAX) begin
      return {1'b1, CMAX[COORD_WIDTH-1:0]};
    end else if (h < CMIN) begin
      return {1'b1, CMIN[COORD_WIDTH-1:0]};
    end
    return {1'b0, h[COORD_WIDTH-1:0]};
  endfunction

  logic [COORD_WIDTH:0] rx, ry;

  assign rx = sat(vx_i, hx_i);
  assign ry = sat(vy_i, hy_i);

  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;
  logic                          clip_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_x_q <= rx[COORD_WIDTH-1:0];
      out_y_q <= ry[COORD_WIDTH-1:0];
      clip_q  <= rx[COORD_WIDTH] | ry[COORD_WIDTH];
    end
  end

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign clip_o  = clip_q;

endmodule

`default_nettype wire

/* hdl/cubic_spline_interpolator_2d_unit.sv */
// ----------------------------------------------------------------------------
// Two-axis cubic spline interpolator
// An accepted input beat runs through the lane stages and the merge stage.
// Throughput: one beat per cycle; each stage holds only when the stage after
// it is full and stalled, so empty stages keep taking input beats.
// The depth is set by three multiply / round-add Horner steps per axis lane.
// Reset clears the stage valid flags only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_spline_interpolator_2d_unit_assert.svh"

module cubic_spline_interpolator_2d_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int RATIO_BITS  = 16,
  localparam int InW     = RATIO_BITS + 1 + 8 * COORD_WIDTH,
  localparam int InTdW   = ((InW + 7) / 8) * 8,
  localparam int OutTdW  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // ratio, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, zero pad
  input  wire logic [InTdW-1:0]               s_axis_tdata,
  // command
  input  wire logic [csi2d_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_x, out_y, zero pad
  output logic [OutTdW-1:0]                   m_axis_tdata,
  // clipped
  output logic [0:0]                          m_axis_tuser
);

  localparam int NST    = csi2d_pkg::NUM_STAGES;
  localparam int LST    = csi2d_pkg::LANE_STAGES;
  localparam int PT_LSB = RATIO_BITS + 1;
  localparam int W      = COORD_WIDTH;
  localparam int AccW   = COORD_WIDTH + csi2d_pkg::ACC_GUARD;

  localparam logic signed [W-1:0] XMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] XMIN = ~XMAX;

  logic [RATIO_BITS:0] ratio;
  logic signed [W-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;

  assign ratio = s_axis_tdata[RATIO_BITS:0];
  assign p0x   = s_axis_tdata[PT_LSB + 0 * W +: W];
  assign p0y   = s_axis_tdata[PT_LSB + 1 * W +: W];
  assign p1x   = s_axis_tdata[PT_LSB + 2 * W +: W];
  assign p1y   = s_axis_tdata[PT_LSB + 3 * W +: W];
  assign p2x   = s_axis_tdata[PT_LSB + 4 * W +: W];
  assign p2y   = s_axis_tdata[PT_LSB + 5 * W +: W];
  assign p3x   = s_axis_tdata[PT_LSB + 6 * W +: W];
  assign p3y   = s_axis_tdata[PT_LSB + 7 * W +: W];

  logic [NST-1:0]        valid_q, valid_d;
  logic [NST:0]          rdy;
  csi2d_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    rdy[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        valid_d[k] = (k == 0) ? s_axis_tvalid : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl.load     = rdy[LST-1:0];
  assign ctrl.out_load = rdy[NST-1];

  logic signed [AccW-1:0] vx, vy;
  logic                   hx, hy;

  csi2d_lane #(
    .COORD_WIDTH (COORD_WIDTH),
    .RATIO_BITS  (RATIO_BITS)
  ) u_lane_x (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cmd_i   (s_axis_tuser),
    .ratio_i (ratio),
    .p0_i    (p0x),
    .p1_i    (p1x),
    .p2_i    (p2x),
    .p3_i    (p3x),
    .v_o     (vx),
    .halve_o (hx)
  );

  csi2d_lane #(
    .COORD_WIDTH (COORD_WIDTH),
    .RATIO_BITS  (RATIO_BITS)
  ) u_lane_y (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cmd_i   (s_axis_tuser),
    .ratio_i (ratio),
    .p0_i    (p0y),
    .p1_i    (p1y),
    .p2_i    (p2y),
    .p3_i    (p3y),
    .v_o     (vy),
    .halve_o (hy)
  );

  logic signed [W-1:0] out_x, out_y;
  logic                clip;

  csi2d_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .vx_i    (vx),
    .vy_i    (vy),
    .hx_i    (hx),
    .hy_i    (hy),
    .out_x_o (out_x),
    .out_y_o (out_y),
    .clip_o  (clip)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = valid_q[NST-1];
  assign m_axis_tdata  = OutTdW'({out_y, out_x});
  assign m_axis_tuser  = clip;

  logic s_fire, m_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  `CSI2D_ASSERT_IMP(a_ready_with_room, clk_i, rst_ni, valid_q != {NST{1'b1}}, s_axis_tready)
  `CSI2D_ASSERT_NXT(a_count_up, clk_i, rst_ni, s_fire && !m_fire, $countones(valid_q) == $past($countones(valid_q)) + 1)
  `CSI2D_ASSERT_NXT(a_count_down, clk_i, rst_ni, m_fire && !s_fire, $countones(valid_q) + 1 == $past($countones(valid_q)))
  `CSI2D_ASSERT_IMP(a_clip_at_limit, clk_i, rst_ni, m_axis_tvalid && clip, (out_x == XMAX) || (out_x == XMIN) || (out_y == XMAX) || (out_y == XMIN))

endmodule

`default_nettype wire

/* test/tb_cubic_spline_interpolator_2d_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the two-axis cubic spline interpolator
// Streams control-point beats through linear, plain cubic and Catmull-Rom
// modes under random stalls on both sides. Each accepted beat is predicted
// in exact integer math, and output beats are compared field by field, in
// order.
// ----------------------------------------------------------------------------

module tb_cubic_spline_interpolator_2d_unit;

  localparam logic [csi2d_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam longint RATIO_ONE = 64'sd65536;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam int N_RANDOM = 1650;

  typedef struct packed {
    logic [csi2d_pkg::CMD_W-1:0] cmd;
    logic [16:0]                 ratio;
    logic [31:0]                 y3, x3, y2, x2, y1, x1, y0, x0;
  } segment_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        clipped;
  } point_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [279:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  segment_t segments_q[$];
  point_t   points_q[$];
  segment_t offered;
  int       n_accepted = 0;
  int       n_received = 0;
  int       n_errors = 0;
  int       hold_left = 0;
  int       phase = 0;
  bit       draining = 1'b0;

  cubic_spline_interpolator_2d_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint scale_by_ratio(longint a, longint t);
    longint m;
    m = (a < 0) ? -a : a;
    m = (m * t + 64'sd32768) >>> 16;
    return (a < 0) ? -m : m;
  endfunction

  function automatic longint horner_eval(longint c0, longint c1, longint c2, longint c3,
                                         longint t);
    longint v;
    v = scale_by_ratio(c0, t) + c1;
    v = scale_by_ratio(v, t) + c2;
    return scale_by_ratio(v, t) + c3;
  endfunction

  function automatic longint axis_value(logic [csi2d_pkg::CMD_W-1:0] cmd, longint t,
                                        longint p0, longint p1, longint p2, longint p3);
    longint a0, v;
    case (cmd)
      csi2d_pkg::CMD_LINEAR: begin
        return p1 + scale_by_ratio(p2 - p1, t);
      end
      csi2d_pkg::CMD_CUBIC: begin
        a0 = p3 - p2 - p0 + p1;
        return horner_eval(a0, p0 - p1 - a0, p2 - p0, p1, t);
      end
      default: begin
        v = horner_eval(-p0 + 3 * p1 - 3 * p2 + p3, 2 * p0 - 5 * p1 + 4 * p2 - p3,
                        p2 - p0, 2 * p1, t);
        return (v < 0) ? -((-v + 1) >>> 1) : ((v + 1) >>> 1);
      end
    endcase
  endfunction

  function automatic logic [31:0] clamp_coord(longint v, inout logic clip);
    if (v > COORD_MAX) begin
      clip = 1'b1;
      return CMAX;
    end
    if (v < COORD_MIN) begin
      clip = 1'b1;
      return CMIN;
    end
    return v[31:0];
  endfunction

  function automatic point_t interpolate(segment_t s);
    point_t r;
    longint t;
    logic   clip;
    clip = 1'b0;
    t = (s.ratio > 17'd65536) ? RATIO_ONE : longint'(s.ratio);
    r.x = clamp_coord(axis_value(s.cmd, t, longint'($signed(s.x0)), longint'($signed(s.x1)),
                                 longint'($signed(s.x2)), longint'($signed(s.x3))), clip);
    r.y = clamp_coord(axis_value(s.cmd, t, longint'($signed(s.y0)), longint'($signed(s.y1)),
                                 longint'($signed(s.y2)), longint'($signed(s.y3))), clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom_range(0, 1) ? (CMAX - $urandom_range(0, 255))
                                           : (CMIN + $urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_seg(logic [csi2d_pkg::CMD_W-1:0] cmd, logic [16:0] ratio,
                         logic [31:0] x0, logic [31:0] y0, logic [31:0] x1, logic [31:0] y1,
                         logic [31:0] x2, logic [31:0] y2, logic [31:0] x3, logic [31:0] y3);
    segment_t s;
    s.cmd = cmd;
    s.ratio = ratio;
    s.x0 = x0; s.y0 = y0; s.x1 = x1; s.y1 = y1;
    s.x2 = x2; s.y2 = y2; s.x3 = x3; s.y3 = y3;
    segments_q = {segments_q, s};
  endtask

  task automatic add_random_seg();
    logic [csi2d_pkg::CMD_W-1:0] cmd;
    logic [16:0]                 ratio;
    int                          kind;
    int                          sel;
    kind = $urandom_range(0, 9);
    kind = (kind < 4) ? 0 : (kind < 8) ? 1 : 2;
    sel = $urandom_range(0, 19);
    cmd = (sel == 0) ? CMD_SPARE : (sel < 7) ? csi2d_pkg::CMD_LINEAR :
          (sel < 13) ? csi2d_pkg::CMD_CUBIC : csi2d_pkg::CMD_CATMULL;
    sel = $urandom_range(0, 19);
    ratio = (sel == 0) ? 17'($urandom_range(65537, 131071)) :
            (sel == 1) ? 17'd65536 : 17'($urandom_range(0, 65535));
    add_seg(cmd, ratio, rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
            rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at beat %0d: got %h, want %h", what, n_received, got, want);
    n_errors++;
  endtask

  // sender
  always @(posedge clk_i) begin : driver
    bit offer;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        points_q = {points_q, interpolate(offered)};
        n_accepted++;
        if (n_accepted == 1400)
          draining = 1'b1;
        phase <= (n_accepted < 550) ? 0 : (n_accepted < 1100) ? 1 : 2;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (draining && points_q.size() == 0)
          draining = 1'b0;
        offer = segments_q.size() > 0 && !draining &&
                $urandom_range(0, 99) >= ((phase == 0) ? 22 : (phase == 1) ? 82 : 0);
        if (offer) begin
          offered = segments_q.pop_front();
          s_axis_tdata <= {7'd0, offered.y3, offered.x3, offered.y2, offered.x2,
                           offered.y1, offered.x1, offered.y0, offered.x0, offered.ratio};
          s_axis_tuser <= offered.cmd;
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin : monitor
    point_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_received++;
        if (points_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
        end else begin
          want = points_q.pop_front();
          if (m_axis_tdata[31:0] !== want.x)
            report_mismatch("out_x", m_axis_tdata[31:0], want.x);
          if (m_axis_tdata[63:32] !== want.y)
            report_mismatch("out_y", m_axis_tdata[63:32], want.y);
          if (m_axis_tuser[0] !== want.clipped)
            report_mismatch("clipped", 32'(m_axis_tuser[0]), 32'(want.clipped));
        end
        if (n_received == 1200)
          hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= ((phase == 0) ? 82 : (phase == 1) ? 22 : 0);
      end
    end
  end

  initial begin
    add_seg(csi2d_pkg::CMD_LINEAR, 17'd0, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN);
    add_seg(csi2d_pkg::CMD_LINEAR, 17'd65536, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN);
    add_seg(csi2d_pkg::CMD_LINEAR, 17'd32768, 0, 0, 0, 0, 1, 32'hffff_ffff, 0, 0);
    add_seg(csi2d_pkg::CMD_LINEAR, 17'd131071, 5, 7, 0, 100, 100, -32'sd100, 9, 9);
    add_seg(csi2d_pkg::CMD_LINEAR, 17'd65537, 1, 2, 32'h0001_0000, 3, 32'h0003_0000,
            -32'sd3, 4, 5);
    add_seg(csi2d_pkg::CMD_CUBIC, 17'd0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_seg(csi2d_pkg::CMD_CUBIC, 17'd65536, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    add_seg(csi2d_pkg::CMD_CUBIC, 17'd32768, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    add_seg(csi2d_pkg::CMD_CUBIC, 17'd1, 3, -32'sd3, -32'sd7, 7, 11, -32'sd11, -32'sd13, 13);
    add_seg(csi2d_pkg::CMD_CUBIC, 17'd131071, CMIN, 0, 1, 2, CMAX, CMIN, 0, 5);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd0, 0, 0, CMAX, CMIN, 0, 0, 0, 0);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd32768, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd65536, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd16384, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd1, 1, -32'sd1, 3, -32'sd3, -32'sd5, 5, 7, -32'sd7);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd32768, 0, 0, 0, 0, 1, 32'hffff_ffff, 0, 0);
    add_seg(CMD_SPARE, 17'd32768, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
            -32'sh0003_0000, 32'h0008_0000, 32'h0005_0000, -32'sh0001_0000, 0);
    add_seg(CMD_SPARE, 17'd131071, CMIN, CMAX, 0, 1, CMAX, CMIN, 5, 6);
    add_seg(csi2d_pkg::CMD_LINEAR, 17'd65535, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
    add_seg(csi2d_pkg::CMD_CUBIC, 17'd65535, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
    add_seg(csi2d_pkg::CMD_CATMULL, 17'd65535, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
    repeat (N_RANDOM) add_random_seg();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (segments_q.size() == 0 && !s_axis_tvalid);
    wait (points_q.size() == 0);
    repeat (16) @(posedge clk_i);
    if (n_errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
